// ===== design/sfd_pkg.sv =====
// Shared types, codes and reset values of the serial frame deframer.
`default_nettype none
package sfd_pkg;

    localparam int unsigned MaxLengthDefault = 256;

    localparam logic [7:0] HdrFirstReset  = 8'h55;
    localparam logic [7:0] HdrSecondReset = 8'hAA;
    localparam logic [7:0] CmdCodeReset   = 8'hFA;

    localparam int unsigned CfgIdxWidth = 2;
    localparam logic [CfgIdxWidth-1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_HDR_SECOND = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CMD_CODE   = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_ZERO_LEN = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] hdr_first;
        logic [7:0] hdr_second;
        logic [7:0] cmd_code;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] first_byte;
        logic       hit;
        logic [7:0] count;
    } t_result;

endpackage
`default_nettype wire

// ===== design/sfd_parser.sv =====
// Frame parser: header hunt, length capture, checksum and result build.
`default_nettype none
module sfd_parser #(
    parameter int unsigned MAX_LENGTH = sfd_pkg::MaxLengthDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfd_pkg::t_cfg   i_cfg,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    output logic                 o_emit,
    output sfd_pkg::t_result     o_result
);
    import sfd_pkg::*;

    localparam int unsigned CntWidth = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [15:0] MaxLen = 16'(MAX_LENGTH);

    t_phase              r_phase, n_phase;
    logic [15:0]         r_len, n_len;
    logic [CntWidth-1:0] r_seen, n_seen;
    logic [7:0]          r_sum, n_sum;
    logic [7:0]          r_first, n_first;

    logic [15:0] len_full;
    logic [16:0] seen_plus2;
    logic [7:0]  sum_add;
    logic [7:0]  count;

    assign len_full   = {r_len[15:8], i_byte};
    assign seen_plus2 = 17'(r_seen) + 17'd2;
    assign sum_add    = r_sum + i_byte;
    assign count      = 8'(r_len - 16'd1);

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_seen   = r_seen;
        n_sum    = r_sum;
        n_first  = r_first;
        o_emit   = 1'b0;
        o_result = '{status: ST_GOOD, first_byte: 8'd0, hit: 1'b0, count: 8'd0};
        unique case (r_phase)
            PH_HUNT2: begin
                if (i_byte == i_cfg.hdr_second) begin
                    n_sum   = sum_add;
                    n_phase = PH_LEN_HI;
                end else if (i_byte == i_cfg.hdr_first) begin
                    n_sum   = i_byte;
                    n_phase = PH_HUNT2;
                end else begin
                    n_sum   = 8'd0;
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'd0};
                n_sum   = sum_add;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = len_full;
                n_sum   = sum_add;
                n_seen  = '0;
                n_first = 8'd0;
                if (len_full == 16'd0) begin
                    n_phase         = PH_HUNT1;
                    n_sum           = 8'd0;
                    o_emit          = 1'b1;
                    o_result.status = ST_ZERO_LEN;
                end else if (len_full > MaxLen) begin
                    n_phase         = PH_HUNT1;
                    n_sum           = 8'd0;
                    o_emit          = 1'b1;
                    o_result.status = ST_TOO_LONG;
                end else if (len_full == 16'd1) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_seen == '0) begin
                    n_first = i_byte;
                end
                n_sum  = sum_add;
                n_seen = r_seen + CntWidth'(1);
                if (seen_plus2 >= {1'b0, r_len}) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase         = PH_HUNT1;
                n_sum           = 8'd0;
                o_emit          = 1'b1;
                o_result.count  = count;
                if (i_byte == r_sum) begin
                    o_result.status     = ST_GOOD;
                    o_result.first_byte = r_first;
                    o_result.hit        = (r_len > 16'd1) && (r_first == i_cfg.cmd_code);
                end else begin
                    o_result.status = ST_BAD_SUM;
                end
            end
            default: begin
                if (i_byte == i_cfg.hdr_first) begin
                    n_sum   = i_byte;
                    n_phase = PH_HUNT2;
                end else begin
                    n_sum   = 8'd0;
                    n_phase = PH_HUNT1;
                end
            end
        endcase
        if (!i_take) begin
            o_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_len   <= 16'd0;
            r_seen  <= '0;
            r_sum   <= 8'd0;
            r_first <= 8'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_first <= n_first;
        end
    end

`ifndef NO_ASSERTIONS
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> (r_len > 16'd1) && (r_len <= MaxLen))
        else $error("payload phase with a length outside the accepted range");
    a_check_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CHECK |-> (r_len != 16'd0) && (r_len <= MaxLen))
        else $error("checksum phase with a rejected length");
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_take && (r_phase == PH_LEN_LO || r_phase == PH_CHECK))
        else $error("result raised outside length or checksum phase");
`endif

endmodule
`default_nettype wire

// ===== design/serial_frame_deframer_sum8_core.sv =====
// Top level of the serial frame deframer with checksum: config, parser and result register.
//
// Usage:
//   Feed received bytes on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte),
//   one word per handshake. Each frame (header pair, 16-bit big-endian length,
//   payload, 8-bit sum checksum) gives one word on the result channel
//   (o_res_valid / i_res_ready): a checked frame on its checksum byte, a
//   rejected length on the low length byte.
//   Latency: a result shows on o_res_valid the cycle after the byte that closes
//   the frame is taken. Throughput: one byte per cycle when not stalled, set by the single
//   result register; the parser state updates in the same cycle that a byte is taken.
//   Stall: while a result waits and i_res_ready is low, o_rx_ready is low and
//   the parser holds; o_rx_ready comes back in the cycle the result is taken.
//   Reset (i_rst_n low, synchronous): parser hunts for the first header byte,
//   the result register empties, registers return to 0x55 / 0xAA / 0xFA.
//   Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_wr_en is
//   high; 0 first header byte, 1 second header byte, 2 command code.
`default_nettype none
module serial_frame_deframer_sum8_core #(
    parameter int unsigned MAX_LENGTH = sfd_pkg::MaxLengthDefault
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [sfd_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_rx_valid,
    output logic                                 o_rx_ready,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic [1:0]                           o_frame_status,
    output logic [7:0]                           o_first_payload_byte,
    output logic                                 o_command_hit,
    output logic [7:0]                           o_payload_count
);
    import sfd_pkg::*;

    t_cfg    r_cfg;
    t_result r_res;
    logic    r_res_valid;
    logic    take;
    logic    emit;
    t_result result;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign take       = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_first  <= HdrFirstReset;
            r_cfg.hdr_second <= HdrSecondReset;
            r_cfg.cmd_code   <= CmdCodeReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_HDR_FIRST:  r_cfg.hdr_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_cfg.hdr_second <= i_cfg_data;
                CFG_CMD_CODE:   r_cfg.cmd_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfd_parser #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_take   (take),
        .i_byte   (i_rx_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_res_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= result;
        end
    end

    assign o_res_valid          = r_res_valid;
    assign o_frame_status       = r_res.status;
    assign o_first_payload_byte = r_res.first_byte;
    assign o_command_hit        = r_res.hit;
    assign o_payload_count      = r_res.count;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");
    a_hit_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_command_hit |-> o_frame_status == ST_GOOD)
        else $error("command hit on a bad frame");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_status != ST_GOOD |-> o_first_payload_byte == 8'd0)
        else $error("payload byte reported on a rejected frame");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(r_res))
        else $error("stalled result lost or changed");
`endif

endmodule
`default_nettype wire
